### rtl/core/ght_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ght_pkg: shared types and constants of the generational handle table
// Slot geometry, request and status codes, and the find-first and popcount
// helpers over the occupancy vector.
// ----------------------------------------------------------------------------
package ght_pkg;

  localparam int SLOTS     = 64;
  localparam int SLOT_W    = $clog2(SLOTS);
  localparam int CNT_W     = SLOT_W + 1;
  localparam int GEN_W     = 16;
  localparam int GEN_SHIFT = 16;
  localparam int DESC_W    = 32;

  // Occupancy scans run in groups of eight slots.
  localparam int GRP    = 8;
  localparam int GRP_W  = $clog2(GRP);
  localparam int NGRP   = SLOTS / GRP;
  localparam int GSEL_W = SLOT_W - GRP_W;

  localparam logic [GEN_W-1:0] GEN_INIT = GEN_W'(1);

  typedef enum logic [1:0] {
    ACT_ALLOC  = 2'd0,
    ACT_LOOKUP = 2'd1,
    ACT_FREE   = 2'd2,
    ACT_COUNT  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_BAD  = 2'd2
  } status_e;

  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] idx;
  } ffs_t;

  // Lowest set bit: per-group priority pick, then pick the lowest group.
  function automatic ffs_t find_first(input logic [SLOTS-1:0] v);
    logic [NGRP-1:0]  g_any;
    logic [GRP_W-1:0] g_idx [NGRP];
    ffs_t             res;
    for (int g = 0; g < NGRP; g++) begin
      g_any[g] = |v[g*GRP +: GRP];
      g_idx[g] = '0;
      for (int j = GRP - 1; j >= 0; j--) begin
        if (v[g*GRP + j]) begin
          g_idx[g] = GRP_W'(j);
        end
      end
    end
    res = '0;
    for (int g = NGRP - 1; g >= 0; g--) begin
      if (g_any[g]) begin
        res.found = 1'b1;
        res.idx   = {GSEL_W'(g), g_idx[g]};
      end
    end
    return res;
  endfunction

  // Population count: per-group sums, then a sum over the groups.
  function automatic logic [CNT_W-1:0] pop_count(input logic [SLOTS-1:0] v);
    logic [GRP_W:0]   g_cnt [NGRP];
    logic [CNT_W-1:0] total;
    for (int g = 0; g < NGRP; g++) begin
      g_cnt[g] = '0;
      for (int j = 0; j < GRP; j++) begin
        g_cnt[g] = g_cnt[g] + {{GRP_W{1'b0}}, v[g*GRP + j]};
      end
    end
    total = '0;
    for (int g = 0; g < NGRP; g++) begin
      total = total + CNT_W'(g_cnt[g]);
    end
    return total;
  endfunction

endpackage
`default_nettype wire

### rtl/core/ght_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ght_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ght_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

### rtl/core/generational_handle_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// generational_handle_table: slot allocator issuing generation-tagged handles
// Allocate, lookup, free and count over a 64-slot table of occupied bits and
// 16-bit generations; handles are generation<<16 | slot.
// ----------------------------------------------------------------------------
// The table takes one request per clock and returns one result per request,
// in order. On acceptance the slot's generation is read from the generation
// RAM (registered read, addressed by the free-slot search, the lookup slot
// or the free slot) into the evaluation stage, which then evaluates the
// request and loads the output register. Sustained throughput is one
// request per cycle as long as the result side keeps up; input ready drops
// only while the output register is held. After reset every slot is free
// with generation 1 and no clearing pass is needed; the table is usable in
// the first cycle after reset. Write active_size only while no request is
// in flight; zero or any value above 64 selects all 64 slots.
// ----------------------------------------------------------------------------
module generational_handle_table (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration: active_size
  input  wire logic        cfg_we_i,
  input  wire logic [6:0]  cfg_wdata_i,
  // request stream
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [39:0] s_axis_tdata_i,   // descriptor[31:0], slot_index[37:32], zero
  input  wire logic [1:0]  s_axis_tuser_i,   // action[1:0]
  // result stream
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic      [47:0] m_axis_tdata_o,   // handle[31:0], found_slot[37:32],
                                             // live_count[44:38], zero
  output logic      [1:0]  m_axis_tuser_o    // status[1:0]
);

  localparam int SLOTS  = ght_pkg::SLOTS;
  localparam int SLOT_W = ght_pkg::SLOT_W;
  localparam int CNT_W  = ght_pkg::CNT_W;
  localparam int GEN_W  = ght_pkg::GEN_W;
  localparam int DESC_W = ght_pkg::DESC_W;

  // --------------------------------------------------------------------------
  // Request decode
  // --------------------------------------------------------------------------
  ght_pkg::action_e    in_act;
  logic [DESC_W-1:0]   in_desc;
  logic [SLOT_W-1:0]   in_sidx;
  logic                accept;

  assign in_act  = ght_pkg::action_e'(s_axis_tuser_i);
  assign in_desc = s_axis_tdata_i[DESC_W-1:0];
  assign in_sidx = s_axis_tdata_i[DESC_W +: SLOT_W];

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  logic [SLOTS-1:0]  occ_q, occ_d;         // occupied bits
  logic [SLOTS-1:0]  gen_vld_q, gen_vld_d; // generation written since reset
  logic [CNT_W-1:0]  active_q, active_d;
  logic [SLOTS-1:0]  mask_q, mask_d;       // slots below active_size

  // Evaluation stage registers
  logic                s1_vld_q, s1_vld_d;
  ght_pkg::action_e    s1_act_q;
  logic [DESC_W-1:0]   s1_desc_q;
  logic [SLOT_W-1:0]   s1_addr_q;         // slot whose generation was read
  logic                s1_aok_q;          // a free slot existed for allocate
  logic                hit_q;             // read collided with a write
  logic [GEN_W-1:0]    byp_q;             // data of that write

  // Output register
  logic                out_vld_q, out_vld_d;
  ght_pkg::status_e    out_st_q, out_st_d;
  logic [DESC_W-1:0]   out_hdl_q, out_hdl_d;
  logic [SLOT_W-1:0]   out_slot_q, out_slot_d;
  logic [CNT_W-1:0]    out_live_q, out_live_d;

  logic                s1_fire;

  // --------------------------------------------------------------------------
  // Handshake: advance the evaluation stage whenever the output register is
  // empty or being drained this cycle.
  // --------------------------------------------------------------------------
  assign s1_fire         = s1_vld_q & (~out_vld_q | m_axis_tready_i);
  assign s_axis_tready_o = ~s1_vld_q | s1_fire;
  assign accept          = s_axis_tvalid_i & s_axis_tready_o;

  // --------------------------------------------------------------------------
  // Evaluation of the request held in the stage
  // --------------------------------------------------------------------------
  logic [GEN_W-1:0]  ram_rdata;
  logic [GEN_W-1:0]  gen_rd;
  logic [GEN_W-1:0]  gen_inc;
  logic              occ_bit;
  logic              lk_ok;
  logic              fr_ok;
  logic [CNT_W-1:0]  live;
  logic              ram_we;

  always_comb begin
    // Generation of the addressed slot: forwarded write, RAM, or reset value.
    if (hit_q) begin
      gen_rd = byp_q;
    end else if (gen_vld_q[s1_addr_q]) begin
      gen_rd = ram_rdata;
    end else begin
      gen_rd = ght_pkg::GEN_INIT;
    end

    // Bump the generation, skipping zero.
    gen_inc = gen_rd + GEN_W'(1);
    if (gen_inc == '0) begin
      gen_inc = ght_pkg::GEN_INIT;
    end

    occ_bit = occ_q[s1_addr_q];
    lk_ok   = (s1_desc_q[ght_pkg::GEN_SHIFT-1:SLOT_W] == '0)
            & ({1'b0, s1_desc_q[SLOT_W-1:0]} < active_q)
            & occ_bit
            & (gen_rd == s1_desc_q[DESC_W-1:ght_pkg::GEN_SHIFT]);
    fr_ok   = occ_bit;
    live    = ght_pkg::pop_count(occ_q & mask_q);
  end

  assign ram_we = s1_fire & (s1_act_q == ght_pkg::ACT_FREE) & fr_ok;

  always_comb begin
    out_st_d   = ght_pkg::ST_OK;
    out_hdl_d  = '0;
    out_slot_d = '0;
    out_live_d = '0;
    case (s1_act_q)
      ght_pkg::ACT_ALLOC: begin
        if (s1_aok_q) begin
          out_hdl_d  = {gen_rd, {(ght_pkg::GEN_SHIFT-SLOT_W){1'b0}}, s1_addr_q};
          out_slot_d = s1_addr_q;
        end else begin
          out_st_d = ght_pkg::ST_FULL;
        end
      end
      ght_pkg::ACT_LOOKUP: begin
        if (lk_ok) begin
          out_hdl_d  = s1_desc_q;
          out_slot_d = s1_addr_q;
        end else begin
          out_st_d = ght_pkg::ST_BAD;
        end
      end
      ght_pkg::ACT_FREE: begin
        if (!fr_ok) begin
          out_st_d = ght_pkg::ST_BAD;
        end
      end
      ght_pkg::ACT_COUNT: begin
        out_live_d = live;
      end
      default: begin
        out_st_d = ght_pkg::ST_OK;
      end
    endcase
  end

  // Apply the stage's update to the occupied and written bits as it retires.
  always_comb begin
    occ_d     = occ_q;
    gen_vld_d = gen_vld_q;
    if (s1_fire && (s1_act_q == ght_pkg::ACT_ALLOC) && s1_aok_q) begin
      occ_d[s1_addr_q] = 1'b1;
    end
    if (ram_we) begin
      occ_d[s1_addr_q]     = 1'b0;
      gen_vld_d[s1_addr_q] = 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Read stage: pick the slot to read against the occupancy the request will
  // see when it reaches evaluation (the retiring request already applied).
  // --------------------------------------------------------------------------
  ght_pkg::ffs_t      free_pick;
  logic [SLOT_W-1:0]  rd_addr;
  logic               hit_d;

  always_comb begin
    free_pick = ght_pkg::find_first(~occ_d & mask_q);
    case (in_act)
      ght_pkg::ACT_ALLOC:  rd_addr = free_pick.idx;
      ght_pkg::ACT_LOOKUP: rd_addr = in_desc[SLOT_W-1:0];
      ght_pkg::ACT_FREE:   rd_addr = in_sidx;
      default:             rd_addr = in_sidx;
    endcase
    hit_d = ram_we & (s1_addr_q == rd_addr);
  end

  ght_ram #(
    .WIDTH (GEN_W),
    .DEPTH (SLOTS)
  ) u_gen_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (s1_addr_q),
    .wdata_i (gen_inc),
    .re_i    (accept),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // Configuration: zero or above capacity selects the full table.
  // --------------------------------------------------------------------------
  always_comb begin
    active_d = active_q;
    if (cfg_we_i) begin
      if ((cfg_wdata_i == '0) || (cfg_wdata_i > CNT_W'(SLOTS))) begin
        active_d = CNT_W'(SLOTS);
      end else begin
        active_d = cfg_wdata_i;
      end
    end
    for (int i = 0; i < SLOTS; i++) begin
      mask_d[i] = (CNT_W'(i) < active_d);
    end
  end

  // --------------------------------------------------------------------------
  // Valid flags
  // --------------------------------------------------------------------------
  always_comb begin
    s1_vld_d = s1_vld_q;
    if (accept) begin
      s1_vld_d = 1'b1;
    end else if (s1_fire) begin
      s1_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (s1_fire) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_d = 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q     <= '0;
      gen_vld_q <= '0;
      active_q  <= CNT_W'(SLOTS);
      mask_q    <= '1;
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      occ_q     <= occ_d;
      gen_vld_q <= gen_vld_d;
      active_q  <= active_d;
      mask_q    <= mask_d;
      s1_vld_q  <= s1_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload: load the stage on accept, the output register on retire.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_act_q  <= in_act;
      s1_desc_q <= in_desc;
      s1_addr_q <= rd_addr;
      s1_aok_q  <= free_pick.found;
      hit_q     <= hit_d;
      byp_q     <= gen_inc;
    end
    if (s1_fire) begin
      out_st_q   <= out_st_d;
      out_hdl_q  <= out_hdl_d;
      out_slot_q <= out_slot_d;
      out_live_q <= out_live_d;
    end
  end

  // --------------------------------------------------------------------------
  // Result port
  // --------------------------------------------------------------------------
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {3'b000, out_live_q, out_slot_q, out_hdl_q};
  assign m_axis_tuser_o  = out_st_q;

endmodule
`default_nettype wire

### rtl/core/ght_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ght_checker: port-level checks of the generational handle table
// Watches the result stream for reset behavior, handshake rules and the
// structure of issued handles.
// ----------------------------------------------------------------------------
module ght_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [47:0] m_axis_tdata_o,
  input wire logic [1:0]  m_axis_tuser_o
);

  // No result may be pending right out of reset.
  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_axis_tvalid_o)
    else $error("result valid right after reset");

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("stalled result changed");

  // A nonzero handle carries a nonzero generation and the reported slot.
  a_handle_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o == ght_pkg::ST_OK) && (m_axis_tdata_o[31:0] != '0)
      |-> (m_axis_tdata_o[31:16] != '0) && (m_axis_tdata_o[15:6] == '0)
          && (m_axis_tdata_o[5:0] == m_axis_tdata_o[37:32]))
    else $error("malformed handle");

  // Failed requests carry no handle, slot or count.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o != ght_pkg::ST_OK)
      |-> (m_axis_tdata_o[44:0] == '0))
    else $error("failed request returned data");

endmodule

bind generational_handle_table ght_checker u_ght_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
`default_nettype wire

### dv/ght_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ght_result_checker: result predictor and comparator for the handle table
// Watches the request, result and table-size channels, keeps its own copy
// of slot occupancy and generations, and compares each result in order.
// ----------------------------------------------------------------------------
module ght_result_checker
  import ght_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [6:0]  cfg_wdata_i,
  input  logic        req_valid_i,
  input  logic        req_ready_i,
  input  logic [39:0] req_data_i,   // descriptor[31:0], slot_index[37:32], zero
  input  logic [1:0]  req_user_i,   // action[1:0]
  input  logic        rsp_valid_i,
  input  logic        rsp_ready_i,
  input  logic [47:0] rsp_data_i,   // handle[31:0], found_slot[37:32], live_count[44:38]
  input  logic [1:0]  rsp_user_i,   // status[1:0]
  output logic [31:0] mismatches_o,
  output logic [31:0] outstanding_o
);

  typedef struct packed {
    status_e           status;
    logic [DESC_W-1:0] handle;
    logic [SLOT_W-1:0] slot;
    logic [CNT_W-1:0]  live;
  } result_t;

  logic             occupied_q   [SLOTS];
  logic [GEN_W-1:0] generation_q [SLOTS];
  logic [CNT_W-1:0] size_q;
  result_t          due_results [$];
  result_t          want;
  result_t          got;
  int unsigned      mismatches;

  // Run one request against the table copy and return the result it owes.
  function automatic result_t apply_request(input action_e act,
                                            input logic [DESC_W-1:0] desc,
                                            input logic [SLOT_W-1:0] sidx);
    result_t          r;
    int               pick;
    int               live;
    logic [GEN_W-1:0] bumped;
    logic [15:0]      sel;
    r        = '0;
    r.status = ST_OK;
    case (act)
      ACT_ALLOC: begin
        pick = -1;
        for (int i = SLOTS - 1; i >= 0; i--) begin
          if (i < size_q && !occupied_q[i]) pick = i;
        end
        if (pick < 0) begin
          r.status = ST_FULL;
        end else begin
          occupied_q[pick] = 1'b1;
          r.handle = {generation_q[pick], 16'(pick)};
          r.slot   = SLOT_W'(pick);
        end
      end
      ACT_LOOKUP: begin
        sel = desc[15:0];
        if (sel < size_q && occupied_q[sel[SLOT_W-1:0]] &&
            generation_q[sel[SLOT_W-1:0]] == desc[31:16]) begin
          r.handle = desc;
          r.slot   = sel[SLOT_W-1:0];
        end else begin
          r.status = ST_BAD;
        end
      end
      ACT_FREE: begin
        if (occupied_q[sidx]) begin
          // generation zero is skipped so a zero descriptor never matches
          bumped = generation_q[sidx] + 1'b1;
          if (bumped == '0) bumped = GEN_INIT;
          generation_q[sidx] = bumped;
          occupied_q[sidx]   = 1'b0;
        end else begin
          r.status = ST_BAD;
        end
      end
      default: begin
        live = 0;
        for (int i = 0; i < SLOTS; i++) begin
          if (i < size_q && occupied_q[i]) live++;
        end
        r.live = CNT_W'(live);
      end
    endcase
    return r;
  endfunction

  task automatic report_field(input string name, input logic [31:0] want_v,
                              input logic [31:0] got_v);
    if (want_v !== got_v) begin
      mismatches++;
      $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h",
               $time, name, want_v, got_v);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        occupied_q[i]   = 1'b0;
        generation_q[i] = GEN_INIT;
      end
      size_q = CNT_W'(SLOTS);
      due_results.delete();
      mismatches = 0;
      mismatches_o  <= '0;
      outstanding_o <= '0;
    end else begin
      if (rsp_valid_i && rsp_ready_i) begin
        got.status = status_e'(rsp_user_i);
        got.handle = rsp_data_i[31:0];
        got.slot   = rsp_data_i[37:32];
        got.live   = rsp_data_i[44:38];
        if (due_results.size() == 0) begin
          mismatches++;
          $display("%0t ns: result with none expected, got status %0d handle 0x%0h",
                   $time, got.status, got.handle);
        end else begin
          want = due_results.pop_front();
          report_field("status", 32'(want.status), 32'(got.status));
          report_field("handle", want.handle, got.handle);
          report_field("found_slot", 32'(want.slot), 32'(got.slot));
          report_field("live_count", 32'(want.live), 32'(got.live));
        end
      end
      if (req_valid_i && req_ready_i) begin
        due_results.push_back(apply_request(action_e'(req_user_i), req_data_i[31:0],
                                            req_data_i[37:32]));
      end
      if (cfg_we_i) begin
        size_q = (cfg_wdata_i == '0 || cfg_wdata_i > SLOTS) ? CNT_W'(SLOTS) : cfg_wdata_i;
      end
      mismatches_o  <= mismatches;
      outstanding_o <= due_results.size();
    end
  end

endmodule

### dv/generational_handle_table_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// generational_handle_table_test: stimulus and verdict for the handle table
// Drives directed and random request streams through bursty input and a
// stalling result side, cycles one slot back to back through allocate and
// free, and sweeps the table size across its extremes; a separate checker
// compares every result.
// ----------------------------------------------------------------------------
module generational_handle_table_test;
  import ght_pkg::*;

  localparam int IDLE_LIMIT   = 4000;   // cycles with nothing moving
  localparam int HOLD_CYCLES  = 400;    // long result-side hold
  localparam int DRAIN_CYCLES = 4;      // lets the pipe empty, with margin
  localparam int CHURN_PAIRS  = 16;     // slot 0 starts the churn at gen 3
  localparam int PHASE_ITEMS  = 130;
  localparam int NPHASE       = 13;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        cfg_we    = 1'b0;
  logic [6:0]  cfg_wdata = '0;
  logic        s_valid   = 1'b0;
  logic [39:0] s_data    = '0;
  logic [1:0]  s_user    = '0;
  logic        m_ready   = 1'b0;
  wire         s_ready;
  wire         m_valid;
  wire  [47:0] m_data;
  wire  [1:0]  m_user;
  wire  [31:0] mismatches;
  wire  [31:0] outstanding;

  // Table sizes visited by the random phases; zero and values above the
  // capacity both select the full table.
  logic [6:0]  size_plan [NPHASE] = '{7'd64, 7'd4, 7'd1, 7'd2, 7'd127, 7'd8, 7'd0,
                                      7'd3, 7'd33, 7'd64, 7'd5, 7'd17, 7'd100};

  logic [31:0] seen_handle [SLOTS];
  int unsigned sent_count [4];
  int unsigned size_writes;
  int          active_slots;
  int          burst_left;
  int          idle_cycles;
  bit          no_gaps;
  bit          sink_free_run;
  bit          hold_pending;

  generational_handle_table dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user)
  );

  ght_result_checker table_check (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .req_valid_i   (s_valid),
    .req_ready_i   (s_ready),
    .req_data_i    (s_data),
    .req_user_i    (s_user),
    .rsp_valid_i   (m_valid),
    .rsp_ready_i   (m_ready),
    .rsp_data_i    (m_data),
    .rsp_user_i    (m_user),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side: stall on stretches of its own choosing; serve a long hold
  // when the stimulus asks for one, counting the cycles here.
  initial begin : result_sink
    int mode;
    int stretch;
    mode    = 0;
    stretch = 0;
    forever begin
      @(posedge clk);
      if (sink_free_run) begin
        m_ready <= 1'b1;
      end else if (hold_pending) begin
        hold_pending = 1'b0;
        m_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (stretch == 0) begin
          mode    = $urandom_range(0, 3);
          stretch = $urandom_range(16, 160);
        end
        stretch--;
        case (mode)
          0:       m_ready <= 1'b1;
          1:       m_ready <= 1'($urandom_range(0, 1));
          2:       m_ready <= ($urandom_range(0, 3) == 0);
          default: m_ready <= ~m_ready;
        endcase
      end
    end
  end

  // Remember the last good handle per slot so lookups and frees can aim at
  // live (or recently stale) entries.
  always @(posedge clk) begin
    if (m_valid && m_ready && m_user == ST_OK && m_data[31:0] != '0) begin
      seen_handle[m_data[37:32]] <= m_data[31:0];
    end
  end

  // Watchdog: abort when neither side has moved for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((s_valid && s_ready) || (m_valid && m_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("watchdog: nothing moved for %0d cycles, %0d results outstanding",
                 IDLE_LIMIT, outstanding);
        $display("generational_handle_table_test: errors");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Offer one request and hold it until taken. Between bursts, drop valid
  // for a random gap.
  task automatic send_request(input action_e act, input logic [31:0] desc,
                              input logic [5:0] sidx);
    if (!no_gaps && burst_left == 0) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 2) == 0) ? $urandom_range(50, 150)
                                               : $urandom_range(1, 20);
    end
    if (burst_left > 0) burst_left--;
    s_valid <= 1'b1;
    s_data  <= {2'b00, sidx, desc};
    s_user  <= act;
    do @(posedge clk); while (!s_ready);
    sent_count[act]++;
  endtask

  // Drop valid, wait for every owed result, then let the pipe empty.
  task automatic settle();
    s_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_size(input logic [6:0] v);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    active_slots = (v == '0 || v > SLOTS) ? SLOTS : int'(v);
    size_writes++;
  endtask

  initial begin : stimulus
    logic [31:0] desc;
    logic [5:0]  sidx;
    action_e     act;
    int          pick;
    int          slot;
    int          alloc_pct;
    for (int i = 0; i < SLOTS; i++) seen_handle[i] = '0;
    for (int i = 0; i < 4; i++) sent_count[i] = 0;
    size_writes   = 0;
    active_slots  = SLOTS;
    burst_left    = 0;
    idle_cycles   = 0;
    no_gaps       = 1'b0;
    sink_free_run = 1'b0;
    hold_pending  = 1'b0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty table, first allocations, every lookup failure kind.
    send_request(ACT_COUNT,  32'h0000_0000, 6'd0);
    send_request(ACT_LOOKUP, 32'h0000_0000, 6'd0);   // zero descriptor
    send_request(ACT_FREE,   32'h0000_0000, 6'd5);   // free of an empty slot
    send_request(ACT_ALLOC,  32'hFFFF_FFFF, 6'h3F);  // slot 0, gen 1
    send_request(ACT_ALLOC,  32'h0000_0000, 6'd0);   // slot 1, gen 1
    send_request(ACT_LOOKUP, 32'h0001_0000, 6'h3F);  // good
    send_request(ACT_LOOKUP, 32'h0002_0001, 6'd0);   // generation mismatch
    send_request(ACT_LOOKUP, 32'h0001_0040, 6'd0);   // slot past the table
    send_request(ACT_LOOKUP, 32'hFFFF_FFFF, 6'd0);
    send_request(ACT_FREE,   32'hFFFF_FFFF, 6'd0);   // slot 0 goes to gen 2
    send_request(ACT_LOOKUP, 32'h0001_0000, 6'd0);   // stale handle
    send_request(ACT_ALLOC,  32'h0000_0000, 6'd0);   // slot 0 again, gen 2
    send_request(ACT_COUNT,  32'hFFFF_FFFF, 6'h3F);
    send_request(ACT_FREE,   32'h0000_0000, 6'h3F);  // highest slot, empty

    // Shrink to one slot: slot 1 stays occupied but out of reach.
    write_size(7'd1);
    send_request(ACT_ALLOC,  32'h0000_0000, 6'd0);   // table full
    send_request(ACT_LOOKUP, 32'h0001_0001, 6'd0);   // occupied, beyond size
    send_request(ACT_COUNT,  32'h0000_0000, 6'd0);   // slot 1 not counted
    send_request(ACT_FREE,   32'h0000_0000, 6'd1);   // free beyond size
    send_request(ACT_FREE,   32'h0000_0000, 6'd0);   // slot 0 goes to gen 3

    // Churn: cycle slot 0 through allocate and free at full rate so each
    // allocate reads the generation that the free before it just wrote, then
    // check current, stale and zero descriptors.
    no_gaps       = 1'b1;
    sink_free_run = 1'b1;
    repeat (CHURN_PAIRS) begin
      send_request(ACT_ALLOC, 32'h0000_0000, 6'd0);
      send_request(ACT_FREE,  32'h0000_0000, 6'd0);
    end
    send_request(ACT_ALLOC,  32'h0000_0000, 6'd0);   // handle 0x00130000
    send_request(ACT_LOOKUP, 32'h0013_0000, 6'd0);
    send_request(ACT_FREE,   32'h0000_0000, 6'd0);   // slot 0 goes to gen 0x14
    send_request(ACT_ALLOC,  32'h0000_0000, 6'd0);
    send_request(ACT_LOOKUP, 32'h0013_0000, 6'd0);   // stale handle
    send_request(ACT_LOOKUP, 32'h0000_0000, 6'd0);
    send_request(ACT_LOOKUP, 32'h0014_0000, 6'd0);
    send_request(ACT_FREE,   32'h0000_0000, 6'd0);
    settle();
    no_gaps       = 1'b0;
    sink_free_run = 1'b0;

    // Random phases: lookups mostly aimed at handles seen live, with stale,
    // nearby and fully random descriptors mixed in; frees mostly within the size.
    for (int p = 0; p < NPHASE; p++) begin
      write_size(size_plan[p]);
      alloc_pct = $urandom_range(20, 55);
      if (p == 3) hold_pending = 1'b1;   // fill the pipe and stall input
      repeat (PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        desc = $urandom();
        sidx = 6'($urandom_range(0, 63));
        if (pick < alloc_pct) begin
          act = ACT_ALLOC;
        end else if (pick < alloc_pct + 20) begin
          act  = ACT_LOOKUP;
          slot = $urandom_range(0, active_slots - 1);
          pick = $urandom_range(0, 9);
          if (pick < 6) desc = seen_handle[slot];
          else if (pick < 8) desc = seen_handle[slot] + 32'h0001_0000;
          else if (pick < 9) desc = {16'($urandom_range(1, 3)), 16'($urandom_range(0, 70))};
        end else if (pick < 90) begin
          act = ACT_FREE;
          if ($urandom_range(0, 99) < 85) sidx = 6'($urandom_range(0, active_slots - 1));
        end else begin
          act = ACT_COUNT;
        end
        send_request(act, desc, sidx);
      end
    end

    settle();
    $display("covered %0d requests: %0d allocate, %0d lookup, %0d free, %0d count",
             sent_count[ACT_ALLOC] + sent_count[ACT_LOOKUP] + sent_count[ACT_FREE] +
             sent_count[ACT_COUNT], sent_count[ACT_ALLOC], sent_count[ACT_LOOKUP],
             sent_count[ACT_FREE], sent_count[ACT_COUNT]);
    $display("%0d table-size writes, back-to-back churn on slot 0, a %0d-cycle result hold",
             size_writes, HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("generational_handle_table_test: clean");
    end else begin
      $display("generational_handle_table_test: errors");
    end
    $finish;
  end

endmodule
